[design/csim_pkg.sv]
package csim_pkg;

  localparam int unsigned MaxDimDefault = 1024;
  localparam int unsigned MaxCandDefault = 65535;

  localparam int unsigned ElemW = 16;
  localparam int unsigned VecLenW = 11;
  localparam int unsigned CandW = 16;
  localparam int unsigned PosW = 10;

  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] AddrVecLen = 3'd0;
  localparam logic [CfgAddrW-1:0] AddrCandCnt = 3'd4;

  typedef enum logic {
    CMD_QUERY_WRITE = 1'b0,
    CMD_CANDIDATE   = 1'b1
  } cmd_t;

  // One finished candidate vector handed from the accumulator to the divider.
  typedef struct packed {
    logic signed [63:0] dot;
    logic [63:0]        qsum;
    logic [63:0]        csum;
    logic [CandW-1:0]   index;
    logic               last;
  } sums_t;

endpackage

[design/csim_ram.sv]
module csim_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/csim_front.sv]
// Accepts words, writes the query store and accumulates candidate sums.
// A pipelined path: store read, then multiply-accumulate.
module csim_front #(
  parameter int unsigned MAX_DIM = csim_pkg::MaxDimDefault,
  parameter int unsigned MAX_CANDIDATES = csim_pkg::MaxCandDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic [csim_pkg::PosW-1:0]      position,
  input  logic signed [csim_pkg::ElemW-1:0] element,
  input  logic [csim_pkg::VecLenW-1:0]   vec_len,
  input  logic [csim_pkg::CandW-1:0]     cand_cnt,
  output logic                           sums_valid,
  input  logic                           sums_ready,
  output csim_pkg::sums_t                sums
);

  localparam int unsigned AW = $clog2(MAX_DIM);
  localparam int unsigned ECW = $clog2(MAX_DIM + 1);
  localparam int unsigned CCW = $clog2(MAX_CANDIDATES + 1);

  logic [ECW-1:0] ecnt_r;
  logic [CCW-1:0] ccnt_r;
  logic [ECW-1:0] eff_len;
  logic [CCW-1:0] eff_cnt;
  logic           accept;
  logic           is_cand;
  logic           is_write;
  logic [AW-1:0]  raddr;
  logic [csim_pkg::ElemW-1:0] qraw;

  // Stage one registers
  logic                            s1_v_r;
  logic                            s1_done_r;
  logic signed [csim_pkg::ElemW-1:0] s1_e_r;

  // Stage two registers: products
  logic                            s2_v_r;
  logic                            s2_done_r;
  logic signed [31:0]              p_dot_r;
  logic [31:0]                     p_qq_r;
  logic [31:0]                     p_cc_r;

  logic signed [63:0] dot_r;
  logic [63:0]        qsum_r;
  logic [63:0]        csum_r;
  logic               out_v_r;
  csim_pkg::sums_t    out_r;

  always_comb begin
    if (vec_len == '0) begin
      eff_len = ECW'(1);
    end else if (32'(vec_len) > MAX_DIM) begin
      eff_len = ECW'(MAX_DIM);
    end else begin
      eff_len = ECW'(vec_len);
    end
    if (cand_cnt == '0) begin
      eff_cnt = CCW'(1);
    end else if (32'(cand_cnt) > MAX_CANDIDATES) begin
      eff_cnt = CCW'(MAX_CANDIDATES);
    end else begin
      eff_cnt = CCW'(cand_cnt);
    end
  end

  // The word that ends a vector holds the input off until its sums have
  // left the pipe, so at most one finished vector is ever in flight.
  assign in_ready = !out_v_r && !s1_done_r && !s2_done_r;
  assign accept = in_valid && in_ready;
  assign is_cand = accept && (cmd == csim_pkg::CMD_CANDIDATE);
  assign is_write = accept && (cmd == csim_pkg::CMD_QUERY_WRITE)
                    && (32'(position) < MAX_DIM);
  assign raddr = AW'(ecnt_r);

  csim_ram #(.WIDTH(csim_pkg::ElemW), .DEPTH(MAX_DIM)) u_store (
    .clk   (clk),
    .we    (is_write),
    .waddr (AW'(position)),
    .wdata (element),
    .raddr (raddr),
    .rdata (qraw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecnt_r <= '0;
      ccnt_r <= '0;
      s1_v_r <= 1'b0;
      s1_done_r <= 1'b0;
      s2_v_r <= 1'b0;
      s2_done_r <= 1'b0;
      dot_r <= '0;
      qsum_r <= '0;
      csum_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r <= is_cand;
      s1_e_r <= element;
      s1_done_r <= is_cand && (ecnt_r + ECW'(1) >= eff_len);
      if (is_cand) begin
        if (ecnt_r + ECW'(1) >= eff_len) begin
          ecnt_r <= '0;
        end else begin
          ecnt_r <= ecnt_r + ECW'(1);
        end
      end
      s2_v_r <= s1_v_r;
      s2_done_r <= s1_done_r;
      p_dot_r <= $signed(qraw) * s1_e_r;
      p_qq_r <= 32'($signed(qraw) * $signed(qraw));
      p_cc_r <= 32'(s1_e_r * s1_e_r);
      out_v_r <= (s2_v_r && s2_done_r) || (out_v_r && !sums_ready);
      if (s2_v_r) begin
        if (s2_done_r) begin
          out_r.dot <= dot_r + 64'(p_dot_r);
          out_r.qsum <= qsum_r + 64'(p_qq_r);
          out_r.csum <= csum_r + 64'(p_cc_r);
          out_r.index <= csim_pkg::CandW'(ccnt_r);
          out_r.last <= (ccnt_r + CCW'(1) >= eff_cnt);
          ccnt_r <= (ccnt_r + CCW'(1) >= eff_cnt) ? '0 : ccnt_r + CCW'(1);
          dot_r <= '0;
          qsum_r <= '0;
          csum_r <= '0;
        end else begin
          dot_r <= dot_r + 64'(p_dot_r);
          qsum_r <= qsum_r + 64'(p_qq_r);
          csum_r <= csum_r + 64'(p_cc_r);
        end
      end
    end
  end

  // The output register is always empty when a finished vector reaches the
  // end of the pipe, since no word is taken while one is on its way.
  assign sums_valid = out_v_r;
  assign sums = out_r;

endmodule

[design/csim_queue.sv]
// Two-entry queue between the accumulator and the divider.
module csim_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  csim_pkg::sums_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output csim_pkg::sums_t rd_data
);

  csim_pkg::sums_t slot_r [2];
  logic            wptr_r;
  logic            rptr_r;
  logic [1:0]      cnt_r;
  logic            push;
  logic            pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = slot_r[rptr_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wr_data;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

[design/csim_back.sv]
// Square roots, norm product and division, one bit per cycle.
module csim_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  csim_pkg::sums_t in_sums,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [csim_pkg::ElemW-1:0] cosine,
  output logic [csim_pkg::CandW-1:0] index,
  output logic            last
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_MUL, ST_DIV, ST_DONE
  } state_t;

  state_t        state_r;
  logic [5:0]    step_r;
  logic [63:0]   qv_r, cv_r;
  logic [31:0]   qres_r, cres_r;
  logic [63:0]   den_r;
  logic [79:0]   num_r;
  logic [79:0]   rem_r;
  logic [79:0]   quo_r;
  logic          neg_r;
  logic [6:0]    dstep_r;
  logic [csim_pkg::ElemW-1:0] cos_r;
  logic [csim_pkg::CandW-1:0] idx_r;
  logic          last_r;
  logic          busy_out_r;

  // One restoring square-root step per norm: two bits of the operand each cycle.
  logic [63:0] qbit, qtry, cbit, ctry;
  logic [79:0] rem_sh;
  logic [63:0] mag;
  logic [15:0] sat;

  always_comb begin
    qbit = 64'd1 << {step_r[4:0], 1'b0};
    qtry = {qres_r, 32'd0} >> (6'd31 - step_r[4:0]);
    cbit = qbit;
    ctry = {cres_r, 32'd0} >> (6'd31 - step_r[4:0]);
    rem_sh = {rem_r[78:0], num_r[7'd79 - dstep_r]};
    mag = in_sums.dot[63] ? 64'(-in_sums.dot) : 64'(in_sums.dot);
    if (neg_r) begin
      sat = (quo_r > 80'd32768) ? 16'h8000 : 16'(-quo_r[15:0]);
    end else begin
      sat = (quo_r > 80'd32767) ? 16'h7FFF : quo_r[15:0];
    end
  end

  assign in_ready = state_r == ST_IDLE;
  assign out_valid = busy_out_r;
  assign cosine = cos_r;
  assign index = idx_r;
  assign last = last_r;

  // Digit-by-digit root: at bit k test (res + 2^k)^2 as res<<(k+1) + 4^k.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_out_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            qv_r <= in_sums.qsum;
            cv_r <= in_sums.csum;
            qres_r <= '0;
            cres_r <= '0;
            neg_r <= in_sums.dot[63];
            num_r <= {1'b0, mag, 15'd0};
            idx_r <= in_sums.index;
            last_r <= in_sums.last;
            step_r <= 6'd31;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (qv_r >= qtry + qbit) begin
            qv_r <= qv_r - (qtry + qbit);
            qres_r <= qres_r | (32'd1 << step_r[4:0]);
          end
          if (cv_r >= ctry + cbit) begin
            cv_r <= cv_r - (ctry + cbit);
            cres_r <= cres_r | (32'd1 << step_r[4:0]);
          end
          step_r <= step_r - 6'd1;
          if (step_r == 6'd0) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          den_r <= 64'(qres_r) * 64'(cres_r);
          rem_r <= '0;
          quo_r <= '0;
          dstep_r <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (den_r == '0) begin
            cos_r <= '0;
            busy_out_r <= 1'b1;
            dstep_r <= 7'd81;
            state_r <= ST_DONE;
          end else begin
            if (rem_sh >= 80'(den_r)) begin
              rem_r <= rem_sh - 80'(den_r);
              quo_r <= {quo_r[78:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[78:0], 1'b0};
            end
            dstep_r <= dstep_r + 7'd1;
            if (dstep_r == 7'd79) begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          // Saturation, then the word is offered; a zero divisor skips saturation.
          if (dstep_r == 7'd80) begin
            cos_r <= sat;
            busy_out_r <= 1'b1;
            dstep_r <= 7'd81;
          end else if (out_ready) begin
            busy_out_r <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/cosine_similarity_engine.sv]
// Cosine similarity engine in Q1.15. Write query elements with cmd 0, then stream
// candidate elements with cmd 1; a candidate element is taken every cycle, except
// that the word ending a vector holds the input off until its sums have left the
// multiply-accumulate pipe for the queue. Each finished vector goes through a
// two-entry queue to a serial back end that takes one vector at a time through two
// 32-step square roots in parallel, one multiply, an 80-step division, a saturation
// step and the output handshake, so short vectors are limited by the back end.
// No clearing pass; query entries must be written before they are read.
module cosine_similarity_engine #(
  parameter int unsigned MAX_DIM = csim_pkg::MaxDimDefault,
  parameter int unsigned MAX_CANDIDATES = csim_pkg::MaxCandDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // position[9:0], element[25:10], zero fill
  input  logic        in_tuser,  // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // cosine[15:0], candidate_index[31:16]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [csim_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [csim_pkg::VecLenW-1:0] vec_len_r;
  logic [csim_pkg::CandW-1:0]   cand_cnt_r;
  logic            f_valid, f_ready, b_valid, b_ready;
  csim_pkg::sums_t f_sums, b_sums;
  logic [csim_pkg::ElemW-1:0] cos;
  logic [csim_pkg::CandW-1:0] idx;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_len_r <= csim_pkg::VecLenW'(1);
      cand_cnt_r <= csim_pkg::CandW'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        csim_pkg::AddrVecLen: vec_len_r <= cfg_pwdata[csim_pkg::VecLenW-1:0];
        csim_pkg::AddrCandCnt: cand_cnt_r <= cfg_pwdata[csim_pkg::CandW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      csim_pkg::AddrVecLen: cfg_prdata = 32'(vec_len_r);
      csim_pkg::AddrCandCnt: cfg_prdata = 32'(cand_cnt_r);
      default: cfg_prdata = '0;
    endcase
  end

  csim_front #(.MAX_DIM(MAX_DIM), .MAX_CANDIDATES(MAX_CANDIDATES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .cmd        (in_tuser),
    .position   (in_tdata[9:0]),
    .element    (in_tdata[25:10]),
    .vec_len    (vec_len_r),
    .cand_cnt   (cand_cnt_r),
    .sums_valid (f_valid),
    .sums_ready (f_ready),
    .sums       (f_sums)
  );

  csim_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_sums),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_sums)
  );

  csim_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_sums   (b_sums),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cosine    (cos),
    .index     (idx),
    .last      (out_tlast)
  );

  assign out_tdata = {idx, cos};

endmodule

[design/csim_checker.sv]
module csim_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind cosine_similarity_engine csim_checker u_csim_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainWait = 400;

  typedef struct packed {
    logic signed [15:0] cosine;
    logic [15:0]        index;
    logic               last;
  } score_t;

  typedef struct {
    csim_pkg::cmd_t     cmd;
    logic [9:0]         pos;
    logic signed [15:0] elem;
    bit                 typed;
    logic signed [15:0] cosine;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;  // position[9:0], element[25:10], zero fill
  logic        in_tuser;  // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata; // cosine[15:0], candidate_index[31:16]
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [csim_pkg::CfgAddrW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cosine_similarity_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Predictor state.
  logic [15:0]        query_mem [StoreDepth];
  bit                 query_valid [StoreDepth];
  int unsigned        elem_idx;
  int unsigned        cand_idx;
  longint             dot_acc;
  longint unsigned    qnorm_acc;
  longint unsigned    cnorm_acc;
  logic [10:0]        len_reg;
  logic [15:0]        count_reg;

  score_t      pending_scores [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned words_sent;
  int unsigned burst_left;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned t;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  function automatic int unsigned eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > StoreDepth) return StoreDepth;
    return len_reg;
  endfunction

  function automatic logic signed [15:0] cosine_of(longint dot, longint unsigned qs,
                                                    longint unsigned cs);
    longint unsigned den;
    longint unsigned mag;
    longint unsigned q;
    den = floor_sqrt(qs) * floor_sqrt(cs);
    if (den == 0) return 16'sd0;
    mag = (dot < 0) ? longint'(-dot) : longint'(dot);
    q = (mag << 15) / den;
    if (dot < 0) begin
      if (q > 32768) q = 32768;
      return 16'(-q[15:0]);
    end
    if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  task automatic predict_word(input csim_pkg::cmd_t cmd, input logic [9:0] pos,
                              input logic signed [15:0] elem,
                              output bit got, output score_t s);
    longint qv;
    bit is_last;
    got = 1'b0;
    s = '0;
    if (cmd == csim_pkg::CMD_QUERY_WRITE) begin
      query_mem[pos] = elem;
      query_valid[pos] = 1'b1;
      return;
    end
    qv = longint'($signed(query_mem[elem_idx % StoreDepth]));
    dot_acc += qv * longint'(elem);
    qnorm_acc += longint'(qv * qv);
    cnorm_acc += longint'(longint'(elem) * longint'(elem));
    elem_idx++;
    if (elem_idx < eff_len()) return;
    is_last = (cand_idx + 1 >= ((count_reg == 0) ? 1 : count_reg));
    s.cosine = cosine_of(dot_acc, qnorm_acc, cnorm_acc);
    s.index = cand_idx[15:0];
    s.last = is_last;
    got = 1'b1;
    elem_idx = 0;
    dot_acc = 0;
    qnorm_acc = 0;
    cnorm_acc = 0;
    cand_idx = is_last ? 0 : cand_idx + 1;
  endtask

  // Sender: bursts of random length, random gaps in between.
  task automatic send_word(input csim_pkg::cmd_t cmd, input logic [9:0] pos,
                           input logic signed [15:0] elem,
                           input bit typed, input logic signed [15:0] typed_cos);
    bit got;
    score_t s;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {6'b0, elem, pos};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    predict_word(cmd, pos, elem, got, s);
    if (got) begin
      if (typed) s.cosine = typed_cos;
      pending_scores.push_back(s);
    end
  endtask

  // Candidate element; the query entry it reads is written first when needed.
  task automatic send_cand(input logic signed [15:0] elem);
    int unsigned p;
    p = elem_idx % StoreDepth;
    if (!query_valid[p])
      send_word(csim_pkg::CMD_QUERY_WRITE, p[9:0], 16'($urandom_range(0, 65535)), 0, 0);
    send_word(csim_pkg::CMD_CANDIDATE, 10'd0, elem, 0, 0);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_scores.size() != 0) @(posedge clk);
    // The block may still be busy on a vector that gives no result yet.
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic [csim_pkg::CfgAddrW-1:0] addr,
                           input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == csim_pkg::AddrVecLen) len_reg = data[10:0];
    else count_reg = data[15:0];
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Receiver stalls in one of four modes: always ready, or ready at random.
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    score_t got_s;
    score_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_s.cosine = out_tdata[15:0];
      got_s.index = out_tdata[31:16];
      got_s.last = out_tlast;
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: cosine %0d index %0d last %0d",
                   got_s.cosine, got_s.index, got_s.last);
      end else begin
        want = pending_scores.pop_front();
        if (got_s !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected cosine %0d index %0d last %0d, got %0d %0d %0d",
                     want.cosine, want.index, want.last,
                     got_s.cosine, got_s.index, got_s.last);
        end
      end
    end
  end

  row_t rows [$];
  logic [10:0] len_pick;
  logic [15:0] count_pick;
  int unsigned nvec;
  int unsigned vmode;
  int unsigned vl;
  logic [15:0] qe;

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    words_sent = 0;
    burst_left = 0;
    elem_idx = 0;
    cand_idx = 0;
    dot_acc = 0;
    qnorm_acc = 0;
    cnorm_acc = 0;
    len_reg = 11'd1;
    count_reg = 16'd1;
    foreach (query_valid[i]) query_valid[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset settings: one element per vector, one per batch.
    rows = '{
      '{csim_pkg::CMD_QUERY_WRITE, 10'd0,    16'sh7FFF, 0, 0},
      '{csim_pkg::CMD_CANDIDATE,   10'd0,    16'sh7FFF, 1, 16'sh7FFF},
      '{csim_pkg::CMD_QUERY_WRITE, 10'd0,    16'sh8000, 0, 0},
      '{csim_pkg::CMD_CANDIDATE,   10'd0,    16'sh7FFF, 1, 16'sh8000},
      '{csim_pkg::CMD_CANDIDATE,   10'd0,    16'sh8000, 1, 16'sh7FFF},
      '{csim_pkg::CMD_CANDIDATE,   10'd0,    16'sh0000, 1, 16'sh0000},
      '{csim_pkg::CMD_QUERY_WRITE, 10'd1023, 16'shFFFF, 0, 0},
      '{csim_pkg::CMD_QUERY_WRITE, 10'd0,    16'sh0000, 0, 0},
      '{csim_pkg::CMD_CANDIDATE,   10'd0,    16'sh3039, 1, 16'sh0000},
      '{csim_pkg::CMD_QUERY_WRITE, 10'd0,    16'sh0001, 0, 0},
      '{csim_pkg::CMD_CANDIDATE,   10'd0,    16'shFFFF, 1, 16'sh8000},
      '{csim_pkg::CMD_QUERY_WRITE, 10'd0,    16'sh5555, 0, 0},
      '{csim_pkg::CMD_CANDIDATE,   10'd0,    16'sh2AAA, 0, 0},
      '{csim_pkg::CMD_QUERY_WRITE, 10'd512,  16'sh1234, 0, 0}
    };
    foreach (rows[i])
      send_word(rows[i].cmd, rows[i].pos, rows[i].elem, rows[i].typed, rows[i].cosine);

    // Random phases; each ends idle so the registers can change.
    while (words_sent < 950) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: len_pick = 11'd0;
        1: len_pick = 11'd48;
        2: len_pick = 11'd64;
        default: len_pick = 11'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 5))
        0: count_pick = 16'd0;
        1: count_pick = 16'hFFFF;
        default: count_pick = 16'($urandom_range(1, 6));
      endcase
      write_reg(csim_pkg::AddrVecLen, {21'b0, len_pick});
      write_reg(csim_pkg::AddrCandCnt, {16'b0, count_pick});
      vl = eff_len();
      for (int i = 0; i < vl; i++)
        if ($urandom_range(0, 1) == 0 || !query_valid[i])
          send_word(csim_pkg::CMD_QUERY_WRITE, i[9:0], rand_elem(), 0, 0);
      // Long vectors come in ones and twos to keep the word count in range.
      nvec = (vl > 16) ? $urandom_range(1, 2) : $urandom_range(2, 10);
      for (int v = 0; v < nvec; v++) begin
        vmode = $urandom_range(0, 7);
        for (int k = 0; k < vl; k++) begin
          // An occasional query write lands in the middle of a vector.
          if ($urandom_range(0, 15) == 0)
            send_word(csim_pkg::CMD_QUERY_WRITE, 10'($urandom_range(0, 1023)),
                      rand_elem(), 0, 0);
          qe = query_mem[elem_idx % StoreDepth];
          case (vmode)
            0: send_cand(16'sd0);
            1: send_cand(query_valid[elem_idx % StoreDepth] ? qe : rand_elem());
            2: send_cand(query_valid[elem_idx % StoreDepth] ? -qe : rand_elem());
            default: send_cand(rand_elem());
          endcase
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0 && pending_scores.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
